>>> rtl/core/harris_corner_response_assert.svh
// Assertion macros for the Harris corner response RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef HARRIS_CORNER_RESPONSE_ASSERT_SVH
`define HARRIS_CORNER_RESPONSE_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define HCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define HCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hcr_pkg.sv
// Types, constants and helper functions of the Harris corner response block.
// No dependencies; the other RTL files, but for the assertion header, use this package.
package hcr_pkg;

  localparam int POS_W   = 13;   // pixel position, covers the widest frame
  localparam int DIM_W   = 14;   // frame size and raster counters
  localparam int PEND_W  = 15;   // pending count, up to 2W+2
  localparam int SLOT_W  = 3;    // eight row slots in the pixel store
  localparam int PIX_W   = 8;
  localparam int K_W     = 10;
  localparam int SIZE_W  = 12;
  localparam int RESP_W  = 42;
  localparam int OPOS_W  = 11;
  localparam int GRAD_W  = 12;
  localparam int PROD_W  = 22;
  localparam int WGT_W   = 31;
  localparam int WSUM_W  = 56;
  localparam int GS_W    = 25;
  localparam int KT_W    = 62;
  localparam int REM_W   = 15;
  localparam int IDX_W   = 4;

  localparam logic [REM_W-1:0]  DIVISOR   = 15'd10000;
  localparam logic [IDX_W-1:0]  LAST_POS  = 4'd8;
  localparam logic [SIZE_W-1:0] MIN_DIM   = 12'd3;

  localparam logic [K_W-1:0]    RST_K      = 10'd400;
  localparam logic [SIZE_W-1:0] RST_WIDTH  = 12'd640;
  localparam logic [SIZE_W-1:0] RST_HEIGHT = 12'd480;

  localparam logic signed [63:0] RESP_MAX64 = 64'sd2199023255551;
  localparam logic signed [63:0] RESP_MIN64 = -64'sd2199023255552;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic [1:0] CFG_K      = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  col;
    logic [PIX_W-1:0]  data;
  } wr_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [K_W-1:0]   k;
  } frame_t;

  typedef enum logic [3:0] {
    BS_IDLE, BS_SETUP, BS_READ, BS_WAIT, BS_MUL1, BS_MUL2, BS_ACC, BS_ROUND,
    BS_FIN1, BS_FIN2, BS_FIN3, BS_FIN4, BS_DSTART, BS_DIV, BS_SAT, BS_OUT
  } back_state_t;

  // row offset (0..2) of a 3x3 window position
  function automatic logic [1:0] pos_dy(input logic [IDX_W-1:0] idx);
    logic [1:0] d;
    unique case (idx) inside
      4'd0, 4'd1, 4'd2: d = 2'd0;
      4'd3, 4'd4, 4'd5: d = 2'd1;
      4'd6, 4'd7, 4'd8: d = 2'd2;
      default:          d = 2'd0;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] pos_dx(input logic [IDX_W-1:0] idx);
    logic [1:0] d;
    unique case (idx) inside
      4'd0, 4'd3, 4'd6: d = 2'd0;
      4'd1, 4'd4, 4'd7: d = 2'd1;
      4'd2, 4'd5, 4'd8: d = 2'd2;
      default:          d = 2'd0;
    endcase
    return d;
  endfunction

  // Gaussian weight, outer product of the Q0.16 taps
  function automatic logic signed [WGT_W-1:0] gauss_wgt(input logic [IDX_W-1:0] idx);
    logic signed [WGT_W-1:0] w;
    unique case (idx) inside
      4'd0, 4'd2, 4'd6, 4'd8: w = 31'sd437520889;
      4'd1, 4'd3, 4'd5, 4'd7: w = 31'sd495774734;
      4'd4:                   w = 31'sd561784804;
      default:                w = '0;
    endcase
    return w;
  endfunction

  function automatic logic signed [2:0] gx_coef(input logic [IDX_W-1:0] idx);
    logic signed [2:0] c;
    unique case (idx) inside
      4'd0, 4'd6: c = -3'sd1;
      4'd2, 4'd8: c = 3'sd1;
      4'd3:       c = -3'sd2;
      4'd5:       c = 3'sd2;
      default:    c = 3'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [2:0] gy_coef(input logic [IDX_W-1:0] idx);
    logic signed [2:0] c;
    unique case (idx) inside
      4'd0, 4'd2: c = -3'sd1;
      4'd6, 4'd8: c = 3'sd1;
      4'd1:       c = -3'sd2;
      4'd7:       c = 3'sd2;
      default:    c = 3'sd0;
    endcase
    return c;
  endfunction

  // reflect-101 for an index at most one outside [0, n-1]
  function automatic logic [POS_W-1:0] mirror(input logic signed [15:0] i,
                                              input logic [DIM_W-1:0] n);
    logic signed [15:0] nn;
    logic signed [15:0] v;
    nn = $signed({2'b00, n});
    if (i < 16'sd0)
      v = -i;
    else if (i >= nn)
      v = 16'sd2 * nn - 16'sd2 - i;
    else
      v = i;
    return v[POS_W-1:0];
  endfunction

  // Q0.32 to integer, halves away from zero
  function automatic logic signed [GS_W-1:0] round_q32(input logic signed [WSUM_W-1:0] s);
    logic [WSUM_W-1:0]      mag;
    logic [WSUM_W-1:0]      rm;
    logic signed [GS_W-1:0] q;
    mag = s[WSUM_W-1] ? WSUM_W'(-s) : WSUM_W'(s);
    rm  = mag + {{(WSUM_W-32){1'b0}}, 32'h8000_0000};
    q   = $signed({1'b0, rm[WSUM_W-1:32]});
    return s[WSUM_W-1] ? -q : q;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v, input int hi);
    logic [DIM_W-1:0] r;
    if (v < MIN_DIM)
      r = DIM_W'(MIN_DIM);
    else if (int'(v) > hi)
      r = DIM_W'(hi);
    else
      r = DIM_W'(v);
    return r;
  endfunction

endpackage

>>> rtl/core/hcr_channels.sv
// Handshake channels of the Harris corner response block: pixel in, response out.
// Depends on hcr_pkg for the field widths.
interface hcr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [hcr_pkg::PIX_W-1:0] pixel;

  modport source (output valid, req_type, pixel, input ready);
  modport sink (input valid, req_type, pixel, output ready);
endinterface

interface hcr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [hcr_pkg::RESP_W-1:0] response;
  logic [hcr_pkg::OPOS_W-1:0]        column;
  logic [hcr_pkg::OPOS_W-1:0]        row;
  logic                              frame_end;

  modport source (output valid, response, column, row, frame_end, input ready);
  modport sink (input valid, response, column, row, frame_end, output ready);
endinterface

>>> rtl/core/hcr_front.sv
// Front end: config registers, raster counters, pixel store writes, job issue.
// Depends on hcr_pkg and hcr_channels.
module hcr_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                      clk,
  input  logic                      rst_n,
  hcr_in_if.sink                    in_if,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [hcr_pkg::SIZE_W-1:0] cfg_data,
  input  logic                      q_full,
  input  logic                      back_idle,
  output logic                      push,
  output hcr_pkg::job_t             push_job,
  output hcr_pkg::wr_t              wr,
  output hcr_pkg::frame_t           frame
);
  import hcr_pkg::*;

  logic [K_W-1:0]    k_r;
  logic [SIZE_W-1:0] w_cfg_r, h_cfg_r;
  logic [DIM_W-1:0]  frame_w_r, frame_w_nxt, frame_h_r, frame_h_nxt;
  logic [DIM_W-1:0]  in_col_r, in_col_nxt, in_row_r, in_row_nxt;
  logic [DIM_W-1:0]  out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              draining_r, draining_nxt;
  logic              start, acc;

  assign start       = !draining_r && (in_row_r == '0) && (in_col_r == '0);
  // a new frame waits until the back end no longer reads the old one
  assign in_if.ready = !q_full && !(start && !back_idle);
  assign acc         = in_if.valid && in_if.ready;
  assign frame       = '{w: frame_w_r, h: frame_h_r, k: k_r};

  always_comb begin
    logic [PEND_W-1:0] pend;
    logic [DIM_W-1:0]  oc, orw, fw, fh;
    fw = start ? clamp_dim(w_cfg_r, MAX_WIDTH) : frame_w_r;
    fh = start ? clamp_dim(h_cfg_r, MAX_HEIGHT) : frame_h_r;
    pend = pend_r;
    oc   = out_col_r;
    orw  = out_row_r;
    frame_w_nxt  = frame_w_r;
    frame_h_nxt  = frame_h_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    draining_nxt = draining_r;
    push         = 1'b0;
    push_job     = '{row: POS_W'(out_row_r), col: POS_W'(out_col_r), last: 1'b0};
    wr = '{en: 1'b0, slot: in_row_r[SLOT_W-1:0], col: POS_W'(in_col_r), data: in_if.pixel};

    if (acc && (in_if.req_type == REQ_PIXEL) && !draining_r) begin
      frame_w_nxt = fw;
      frame_h_nxt = fh;
      if (start) begin
        pend = '0;
        oc   = '0;
        orw  = '0;
      end
      wr.en = 1'b1;
      pend  = pend + 1'b1;
      if (DIM_W'(in_col_r + 1'b1) >= fw) begin
        in_col_nxt = '0;
        in_row_nxt = DIM_W'(in_row_r + 1'b1);
        if (DIM_W'(in_row_r + 1'b1) >= fh) draining_nxt = 1'b1;
      end else begin
        in_col_nxt = DIM_W'(in_col_r + 1'b1);
      end
      if (pend > PEND_W'({fw, 1'b0}) + PEND_W'(2)) begin
        push     = 1'b1;
        push_job = '{row: POS_W'(orw), col: POS_W'(oc), last: 1'b0};
        pend     = pend - 1'b1;
        if (DIM_W'(oc + 1'b1) >= fw) begin
          oc  = '0;
          orw = DIM_W'(orw + 1'b1);
        end else begin
          oc = DIM_W'(oc + 1'b1);
        end
      end
    end else if (acc && (in_if.req_type == REQ_DRAIN) && draining_r && (pend_r != '0)) begin
      push = 1'b1;
      push_job.last = (pend_r == PEND_W'(1));
      if (pend_r == PEND_W'(1)) begin
        draining_nxt = 1'b0;
        in_col_nxt   = '0;
        in_row_nxt   = '0;
        oc   = '0;
        orw  = '0;
        pend = '0;
      end else begin
        pend = pend_r - 1'b1;
        if (DIM_W'(oc + 1'b1) >= frame_w_r) begin
          oc  = '0;
          orw = DIM_W'(orw + 1'b1);
        end else begin
          oc = DIM_W'(oc + 1'b1);
        end
      end
    end
    pend_nxt    = pend;
    out_col_nxt = oc;
    out_row_nxt = orw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= RST_K;
      w_cfg_r    <= RST_WIDTH;
      h_cfg_r    <= RST_HEIGHT;
      frame_w_r  <= clamp_dim(RST_WIDTH, MAX_WIDTH);
      frame_h_r  <= clamp_dim(RST_HEIGHT, MAX_HEIGHT);
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      pend_r     <= '0;
      draining_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_K))      k_r     <= cfg_data[K_W-1:0];
      if (cfg_we && (cfg_index == CFG_WIDTH))  w_cfg_r <= cfg_data;
      if (cfg_we && (cfg_index == CFG_HEIGHT)) h_cfg_r <= cfg_data;
      frame_w_r  <= frame_w_nxt;
      frame_h_r  <= frame_h_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      pend_r     <= pend_nxt;
      draining_r <= draining_nxt;
    end
  end

endmodule

>>> rtl/core/hcr_queue.sv
// Short job queue between front and back end.
// Depends on hcr_pkg and the assertion macro header.
module hcr_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hcr_pkg::job_t din,
  input  logic          pop,
  output hcr_pkg::job_t dout,
  output logic          full,
  output logic          empty
);
  import hcr_pkg::*;
`include "harris_corner_response_assert.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             store_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = store_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) store_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wp_r + 1'b1);
      if (pop)  rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rp_r + 1'b1);
      if (push && !pop)      count_r <= CNT_W'(count_r + 1'b1);
      else if (pop && !push) count_r <= CNT_W'(count_r - 1'b1);
    end
  end

  `HCR_ASSERT_NOW(a_push_room, push, !full, "job pushed into a full queue")
  `HCR_ASSERT_NOW(a_pop_data, pop, !empty, "job popped from an empty queue")
  `HCR_ASSERT_NEXT(a_count_hold, !push && !pop, $stable(count_r), "queue count moved")

endmodule

>>> rtl/core/hcr_div.sv
// Division of the k*(A+B)^2 term by 10000, four 16-bit digits by reciprocal multiply.
// Depends on hcr_pkg.
module hcr_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [hcr_pkg::KT_W-1:0] dividend,
  output logic                     done,
  output logic [hcr_pkg::KT_W-1:0] quotient,
  output logic                     rem_nz
);
  import hcr_pkg::*;

  // each digit step divides {rem, digit} < 10000 * 2^16 < 2^30 by 10000:
  // q = (v * ceil(2^44 / 10000)) >> 44 is exact over that range
  localparam int DQ_W  = 64;
  localparam int DIG_W = 16;
  localparam int V_W   = REM_W + DIG_W;
  localparam int M_W   = 31;
  localparam int SH    = 44;
  localparam logic [M_W-1:0] RECIP = 31'd1759218605;

  logic [DQ_W-1:0]      dq_r, qacc_r;
  logic [REM_W-1:0]     rem_r;
  logic [V_W-1:0]       v, v_r;
  logic [V_W+M_W-1:0]   prod;
  logic [DIG_W-1:0]     qd_r;
  logic [1:0]           cnt_r;
  logic                 busy_r, phase_r, done_r;

  assign v        = {rem_r, dq_r[DQ_W-1 -: DIG_W]};
  assign prod     = (V_W+M_W)'(v) * (V_W+M_W)'(RECIP);
  assign done     = done_r;
  assign quotient = qacc_r[KT_W-1:0];
  assign rem_nz   = (rem_r != '0);

  // phase 0: quotient digit by reciprocal; phase 1: remainder and shift
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r   <= DQ_W'(dividend);
      qacc_r <= '0;
      rem_r  <= '0;
    end else if (busy_r && !phase_r) begin
      v_r  <= v;
      qd_r <= prod[SH +: DIG_W];
    end else if (busy_r) begin
      rem_r  <= REM_W'(v_r - V_W'(qd_r) * V_W'(DIVISOR));
      qacc_r <= {qacc_r[DQ_W-DIG_W-1:0], qd_r};
      dq_r   <= {dq_r[DQ_W-DIG_W-1:0], {DIG_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
        cnt_r   <= '0;
      end else if (busy_r) begin
        phase_r <= !phase_r;
        if (phase_r) begin
          cnt_r <= 2'(cnt_r + 1'b1);
          if (cnt_r == 2'd3) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/hcr_back.sv
// Back end: pixel store, Sobel and Gaussian sequencer, response arithmetic, output register.
// Depends on hcr_pkg, hcr_channels and hcr_div.
module hcr_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  hcr_pkg::job_t   q_job,
  output logic            pop,
  output logic            idle,
  input  hcr_pkg::wr_t    wr,
  input  hcr_pkg::frame_t frame,
  hcr_out_if.source       out_if
);
  import hcr_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int ADDR_W = SLOT_W + CW;

  back_state_t state_r, state_nxt;

  logic [PIX_W-1:0] mem [2**ADDR_W];
  logic [PIX_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;

  job_t                     job_r;
  logic [IDX_W-1:0]         t_r, p_r, rd_p_r;
  logic                     rd_v_r;
  logic [POS_W-1:0]         y_r, x_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic signed [PROD_W-1:0] pxx_r, pxy_r, pyy_r;
  logic signed [WGT_W+PROD_W-1:0] wxx_r, wxy_r, wyy_r;
  logic signed [WSUM_W-1:0] sa_r, sb_r, sc_r;
  logic signed [GS_W-1:0]   a_r, b_r, c_r;
  logic signed [2*GS_W-1:0] ab_r, cc_r;
  logic signed [GS_W:0]     tr_r;
  logic signed [2*GS_W+1:0] tt_r;
  logic signed [2*GS_W:0]   x_diff_r;
  logic [K_W+26-1:0]        klo_r;
  logic [KT_W-1:0]          kt_r;
  logic signed [RESP_W-1:0] res_r;

  logic                     out_valid_r;
  logic signed [RESP_W-1:0] out_resp_r;
  logic [OPOS_W-1:0]        out_col_r, out_row_r;
  logic                     out_end_r;

  logic div_start, div_done, div_rnz, out_load;
  logic [KT_W-1:0] div_q;

  logic signed [15:0] ry, rx, ty, tx;
  logic [POS_W-1:0]   yy, xx;
  logic signed [GRAD_W-1:0] pv, cgx, cgy;
  logic signed [63:0] ye;

  assign idle      = (state_r == BS_IDLE);
  assign pop       = idle && !q_empty;
  assign div_start = (state_r == BS_DSTART);
  assign out_load  = (state_r == BS_OUT) && (!out_valid_r || out_if.ready);

  // window position of the current read, mirrored twice at the borders
  assign ry      = $signed({3'b000, y_r}) + $signed({14'd0, pos_dy(p_r)}) - 16'sd1;
  assign rx      = $signed({3'b000, x_r}) + $signed({14'd0, pos_dx(p_r)}) - 16'sd1;
  assign yy      = mirror(ry, frame.h);
  assign xx      = mirror(rx, frame.w);
  assign rd_addr = {yy[SLOT_W-1:0], xx[CW-1:0]};
  assign ty      = $signed({3'b000, job_r.row}) + $signed({14'd0, pos_dy(t_r)}) - 16'sd1;
  assign tx      = $signed({3'b000, job_r.col}) + $signed({14'd0, pos_dx(t_r)}) - 16'sd1;

  assign pv  = GRAD_W'($signed({1'b0, rd_data_r}));
  assign cgx = GRAD_W'(gx_coef(rd_p_r));
  assign cgy = GRAD_W'(gy_coef(rd_p_r));

  always_comb begin
    ye = 64'(x_diff_r) - $signed({2'b00, div_q});
    if (div_rnz && (ye > 64'sd0)) ye = ye - 64'sd1;
  end

  hcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (kt_r),
    .done     (div_done),
    .quotient (div_q),
    .rem_nz   (div_rnz)
  );

  always_ff @(posedge clk) begin
    if (wr.en) mem[{wr.slot, wr.col[CW-1:0]}] <= wr.data;
    if (state_r == BS_READ) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BS_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE:   if (!q_empty) state_nxt = BS_SETUP;
      BS_SETUP:  state_nxt = BS_READ;
      BS_READ:   if (p_r == LAST_POS) state_nxt = BS_WAIT;
      BS_WAIT:   state_nxt = BS_MUL1;
      BS_MUL1:   state_nxt = BS_MUL2;
      BS_MUL2:   state_nxt = BS_ACC;
      BS_ACC:    state_nxt = (t_r == LAST_POS) ? BS_ROUND : BS_SETUP;
      BS_ROUND:  state_nxt = BS_FIN1;
      BS_FIN1:   state_nxt = BS_FIN2;
      BS_FIN2:   state_nxt = BS_FIN3;
      BS_FIN3:   state_nxt = BS_FIN4;
      BS_FIN4:   state_nxt = BS_DSTART;
      BS_DSTART: state_nxt = BS_DIV;
      BS_DIV:    if (div_done) state_nxt = BS_SAT;
      BS_SAT:    state_nxt = BS_OUT;
      BS_OUT:    if (out_load) state_nxt = BS_IDLE;
      default:   state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_v_r <= 1'b0;
    else        rd_v_r <= (state_r == BS_READ);
  end

  always_ff @(posedge clk) begin
    rd_p_r <= p_r;
    case (state_r)
      BS_IDLE: begin
        if (pop) begin
          job_r <= q_job;
          t_r   <= '0;
          sa_r  <= '0;
          sb_r  <= '0;
          sc_r  <= '0;
        end
      end
      BS_SETUP: begin
        y_r  <= mirror(ty, frame.h);
        x_r  <= mirror(tx, frame.w);
        p_r  <= '0;
        gx_r <= '0;
        gy_r <= '0;
      end
      BS_READ: p_r <= IDX_W'(p_r + 1'b1);
      BS_MUL1: begin
        pxx_r <= PROD_W'(gx_r) * PROD_W'(gx_r);
        pxy_r <= PROD_W'(gx_r) * PROD_W'(gy_r);
        pyy_r <= PROD_W'(gy_r) * PROD_W'(gy_r);
      end
      BS_MUL2: begin
        wxx_r <= gauss_wgt(t_r) * pxx_r;
        wxy_r <= gauss_wgt(t_r) * pxy_r;
        wyy_r <= gauss_wgt(t_r) * pyy_r;
      end
      BS_ACC: begin
        sa_r <= sa_r + WSUM_W'(wxx_r);
        sc_r <= sc_r + WSUM_W'(wxy_r);
        sb_r <= sb_r + WSUM_W'(wyy_r);
        t_r  <= IDX_W'(t_r + 1'b1);
      end
      BS_ROUND: begin
        a_r <= round_q32(sa_r);
        b_r <= round_q32(sb_r);
        c_r <= round_q32(sc_r);
      end
      BS_FIN1: begin
        ab_r <= (2*GS_W)'(a_r) * (2*GS_W)'(b_r);
        tr_r <= (GS_W+1)'(a_r) + (GS_W+1)'(b_r);
      end
      BS_FIN2: begin
        cc_r <= (2*GS_W)'(c_r) * (2*GS_W)'(c_r);
        tt_r <= (2*GS_W+2)'(tr_r) * (2*GS_W+2)'(tr_r);
      end
      BS_FIN3: begin
        x_diff_r <= (2*GS_W+1)'(ab_r) - (2*GS_W+1)'(cc_r);
        klo_r    <= (K_W+26)'(frame.k) * (K_W+26)'(tt_r[25:0]);
      end
      BS_FIN4: begin
        kt_r <= KT_W'(klo_r)
              + (KT_W'((K_W+26)'(frame.k) * (K_W+26)'(tt_r[2*GS_W+1:26])) << 26);
      end
      BS_SAT: begin
        if (ye > RESP_MAX64)      res_r <= RESP_MAX64[RESP_W-1:0];
        else if (ye < RESP_MIN64) res_r <= RESP_MIN64[RESP_W-1:0];
        else                      res_r <= ye[RESP_W-1:0];
      end
      default: ;
    endcase
    if (rd_v_r) begin
      gx_r <= gx_r + GRAD_W'(pv * cgx);
      gy_r <= gy_r + GRAD_W'(pv * cgy);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_resp_r <= res_r;
      out_col_r  <= OPOS_W'(job_r.col);
      out_row_r  <= OPOS_W'(job_r.row);
      out_end_r  <= job_r.last;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.response  = out_resp_r;
  assign out_if.column    = out_col_r;
  assign out_if.row       = out_row_r;
  assign out_if.frame_end = out_end_r;

endmodule

>>> rtl/core/harris_corner_response.sv
// Top level of the Harris corner response block: front end, job queue, back end.
// Depends on hcr_pkg, hcr_channels, hcr_front, hcr_queue and hcr_back.
//
//   port    dir  handshake       carries
//   in_if   in   valid/ready     req_type, pixel
//   out_if  out  valid/ready     response, column, row, frame_end
//   cfg_*   in   cfg_we only     cfg_index, cfg_data (k_scaled, width, height)
//
// An item that causes no result is not queued. An item that causes a result
// is queued; for each result the back end pops the job, runs nine Gaussian taps,
// each of nine pixel store reads through one read port followed by multiply and
// accumulate, then the response arithmetic, with a divide by 10000 done as four
// 16-bit digits by reciprocal multiplication.
// The input stalls while the four-entry queue is full, and the first pixel of a
// new frame waits until the back end has finished with the previous frame.
// Reset is synchronous, active low; the pixel store needs no clearing, since only
// pixels of the current frame are ever read.
module harris_corner_response #(
  parameter int MAX_WIDTH   = 2048,
  parameter int MAX_HEIGHT  = 2048,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  hcr_in_if.sink                     in_if,
  hcr_out_if.source                  out_if,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [hcr_pkg::SIZE_W-1:0] cfg_data
);
  import hcr_pkg::*;

  job_t   push_job, q_job;
  wr_t    wr;
  frame_t frame;
  logic   push, pop, q_full, q_empty, back_idle, drained;

  // front may start a new frame only when nothing of the old one is in flight
  assign drained = back_idle && q_empty;

  hcr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .back_idle (drained),
    .push      (push),
    .push_job  (push_job),
    .wr        (wr),
    .frame     (frame)
  );

  hcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_job),
    .pop   (pop),
    .dout  (q_job),
    .full  (q_full),
    .empty (q_empty)
  );

  hcr_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (q_job),
    .pop     (pop),
    .idle    (back_idle),
    .wr      (wr),
    .frame   (frame),
    .out_if  (out_if)
  );

endmodule

>>> test/hcr_response_checker.sv
// Response checker for the Harris corner response block: watches the config port
// and both channels, predicts each response and compares it with the block's.
// Depends on hcr_pkg and hcr_channels.
module hcr_response_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  hcr_in_if                          in_mon,
  hcr_out_if                         out_mon,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [hcr_pkg::SIZE_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import hcr_pkg::*;

  typedef struct packed {
    logic [RESP_W-1:0] response;
    logic [OPOS_W-1:0] column;
    logic [OPOS_W-1:0] row;
    logic              frame_end;
  } corner_t;

  corner_t    corner_q[$];
  bit [7:0]   frame_pix[int];
  int         k_reg, w_reg, h_reg, fw, fh;
  int         in_col, in_row, pend, out_col, out_row;
  bit         draining;
  longint     tap[3] = '{20917, 23702, 20917};

  function automatic int reflect(int i, int n);
    if (i < 0) return -i;
    if (i >= n) return 2 * n - 2 - i;
    return i;
  endfunction

  function automatic longint px(int y, int x);
    return longint'(frame_pix[y * 2048 + x]);
  endfunction

  function automatic longint round_half_away(longint s);
    if (s >= 0) return (s + (64'sd1 <<< 31)) >>> 32;
    return -((-s + (64'sd1 <<< 31)) >>> 32);
  endfunction

  function automatic longint corner_score(int r, int c);
    longint sa, sb, sc, gx, gy, wgt, a, b, cc, tr, num, resp;
    int y, x, ym, yp, xm, xp;
    sa = 0; sb = 0; sc = 0;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        y  = reflect(r + dy - 1, fh);
        x  = reflect(c + dx - 1, fw);
        ym = reflect(y - 1, fh); yp = reflect(y + 1, fh);
        xm = reflect(x - 1, fw); xp = reflect(x + 1, fw);
        gx = (px(ym, xp) - px(ym, xm)) + 2 * (px(y, xp) - px(y, xm))
             + (px(yp, xp) - px(yp, xm));
        gy = (px(yp, xm) - px(ym, xm)) + 2 * (px(yp, x) - px(ym, x))
             + (px(yp, xp) - px(ym, xp));
        wgt = tap[dy] * tap[dx];
        sa += wgt * (gx * gx);
        sc += wgt * (gx * gy);
        sb += wgt * (gy * gy);
      end
    end
    a  = round_half_away(sa);
    b  = round_half_away(sb);
    cc = round_half_away(sc);
    tr = a + b;
    num = 10000 * (a * b - cc * cc) - longint'(k_reg) * (tr * tr);
    resp = num / 10000;   // truncates toward zero
    if (resp > RESP_MAX64) resp = RESP_MAX64;
    if (resp < RESP_MIN64) resp = RESP_MIN64;
    return resp;
  endfunction

  function automatic int clamp_size(int v);
    return v < 3 ? 3 : (v > 2048 ? 2048 : v);
  endfunction

  task automatic push_corner(bit last);
    corner_t e;
    longint  s;
    s = corner_score(out_row, out_col);
    e.response  = s[RESP_W-1:0];
    e.column    = out_col[OPOS_W-1:0];
    e.row       = out_row[OPOS_W-1:0];
    e.frame_end = last;
    corner_q.push_back(e);
    pend--;
    out_col++;
    if (out_col >= fw) begin
      out_col = 0;
      out_row++;
    end
  endtask

  // everything sampled mid-cycle: the values that the next rising edge will see
  always @(negedge clk) begin
    corner_t got, want;
    if (!rst_n) begin
      k_reg = RST_K; w_reg = RST_WIDTH; h_reg = RST_HEIGHT;
      fw = clamp_size(w_reg); fh = clamp_size(h_reg);
      in_col = 0; in_row = 0; pend = 0; out_col = 0; out_row = 0;
      draining = 0;
      corner_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_K:      k_reg = cfg_data[K_W-1:0];
          CFG_WIDTH:  w_reg = cfg_data;
          CFG_HEIGHT: h_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.req_type == REQ_PIXEL) begin
          if (!draining) begin
            if (in_row == 0 && in_col == 0) begin
              fw = clamp_size(w_reg); fh = clamp_size(h_reg);
              out_row = 0; out_col = 0; pend = 0;
            end
            frame_pix[in_row * 2048 + in_col] = in_mon.pixel;
            pend++;
            in_col++;
            if (in_col >= fw) begin
              in_col = 0;
              in_row++;
              if (in_row >= fh) draining = 1;
            end
            if (pend > 2 * fw + 2) push_corner(0);
          end
        end else if (draining && pend > 0) begin
          if (pend == 1) begin
            push_corner(1);
            draining = 0;
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
          end else begin
            push_corner(0);
          end
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.response, out_mon.column, out_mon.row, out_mon.frame_end};
        if (corner_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected response %h at row %0d col %0d", $realtime,
                   got.response, got.row, got.column);
        end else begin
          want = corner_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch expected resp=%0d col=%0d row=%0d end=%b",
                     $realtime, $signed(want.response), want.column, want.row,
                     want.frame_end);
            $display("%0t:          actual   resp=%0d col=%0d row=%0d end=%b",
                     $realtime, $signed(got.response), got.column, got.row,
                     got.frame_end);
          end
        end
      end
    end
    outstanding = corner_q.size();
  end
endmodule

>>> test/harris_corner_response_tb.sv
// Top of the Harris corner response testbench: clock, reset, stimulus and verdict.
// Depends on hcr_pkg, hcr_channels, the block and hcr_response_checker.
module harris_corner_response_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hcr_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 400;
  localparam int ITEM_TARGET = 1800;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [SIZE_W-1:0] cfg_data;
  int                fail_count, outstanding;
  int                cycles;
  int                items_sent;
  bit                no_gaps;      // sender runs flat out
  bit                no_stalls;    // receiver ready but for a long stall still running
  int                stall_hold;

  hcr_in_if  in_if ();
  hcr_out_if out_if ();

  harris_corner_response dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hcr_response_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_if), .out_mon(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: mostly short stalls, the odd long one, no new ones when no_stalls is set
  initial begin
    out_if.ready = 0;
    stall_hold   = 0;
  end
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_n) begin
      out_if.ready <= 0;
    end else if (stall_hold > 0) begin
      stall_hold   <= stall_hold - 1;
      out_if.ready <= 0;
    end else if (no_stalls || r < 60) begin
      out_if.ready <= 1;
    end else if (r < 96) begin
      out_if.ready <= 0;
    end else begin
      stall_hold   <= $urandom_range(10, 150);
      out_if.ready <= 0;
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one item; returns at the edge where it was taken
  task automatic send_item(logic req, logic [7:0] pix);
    int  gap;
    bit  taken;
    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1;
    in_if.req_type <= req;
    in_if.pixel    <= pix;
    do begin
      @(negedge clk);
      taken = in_if.ready;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  // block idle: every result in, and the back end given time to settle
  task automatic wait_idle();
    in_if.valid <= 0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // registers change only once every result owed has come out
  task automatic write_regs(int k, int w, int h);
    in_if.valid <= 0;
    while (outstanding != 0) @(posedge clk);
    cfg_we <= 1; cfg_index <= CFG_K;      cfg_data <= SIZE_W'(k);
    @(posedge clk);
    cfg_index <= CFG_WIDTH;  cfg_data <= SIZE_W'(w);
    @(posedge clk);
    cfg_index <= CFG_HEIGHT; cfg_data <= SIZE_W'(h);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [7:0] pick_pixel(int mode, int r, int c, logic [7:0] flat);
    case (mode)
      0:       return 8'($urandom);
      1:       return $urandom_range(0, 1) ? 8'hff : 8'h00;
      2:       return 8'((c * 37 + r * 11) & 255);
      3:       return ((r + c) % 2) ? 8'hff : 8'h00;   // checkerboard
      default: return flat;
    endcase
  endfunction

  // a full frame: pixels, then the drain ticks. Noise adds ignored items:
  // stray drain ticks mid-frame, pixels and spare ticks after the drain starts.
  task automatic run_frame(int w, int h, int mode, bit noise, bit mid_pause);
    logic [7:0] flat;
    flat = 8'($urandom);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (noise && $urandom_range(0, 19) == 0) send_item(REQ_DRAIN, 8'($urandom));
        if (mid_pause && r == h / 2 && c == 0) begin
          // sender holds off until every result owed so far has come
          in_if.valid <= 0;
          while (outstanding != 0) @(posedge clk);
        end
        send_item(REQ_PIXEL, pick_pixel(mode, r, c, flat));
      end
    end
    for (int i = 0; i < 2 * w + 2; i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_item(REQ_PIXEL, 8'($urandom));
      send_item(REQ_DRAIN, 8'($urandom));
    end
    if (noise) send_item(REQ_DRAIN, 8'($urandom));
  endtask

  initial begin
    int w, h;
    rst_n = 0;
    cfg_we = 0; cfg_index = CFG_K; cfg_data = '0;
    in_if.valid = 0; in_if.req_type = REQ_PIXEL; in_if.pixel = '0;
    no_gaps = 0; no_stalls = 0; items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: stray tick before any frame, sizes below range clamp to 3x3
    send_item(REQ_DRAIN, 8'hff);
    wait_idle();
    write_regs(0, 0, 1);
    run_frame(3, 3, 3, 1, 0);
    wait_idle();
    // top of every range written, then a small frame at k = 700
    write_regs(1023, 4095, 4095);
    write_regs(700, 2048, 2048);
    write_regs(700, 5, 4);
    run_frame(5, 4, 1, 0, 0);
    wait_idle();
    write_regs(0, 4, 3);
    run_frame(4, 3, 4, 0, 0);
    wait_idle();

    // a wide frame at full rate with the receiver always ready
    no_gaps = 1; no_stalls = 1;
    write_regs(400, 130, 3);
    run_frame(130, 3, 0, 0, 0);
    wait_idle();
    no_gaps = 0; no_stalls = 0;

    // random frames, mostly small
    while (items_sent < ITEM_TARGET) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      no_gaps   = ($urandom_range(0, 4) == 0);
      no_stalls = ($urandom_range(0, 4) == 0);
      write_regs($urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 700 : 0)
                                           : $urandom_range(0, 700), w, h);
      run_frame(w, h, $urandom_range(0, 4), $urandom_range(0, 3) == 0,
                $urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0) wait_idle();
    end

    in_if.valid <= 0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
